[rtl/least_loaded_server_assigner_defines.svh]
// Assertion macros for the least-loaded server assigner RTL.
`ifndef LEAST_LOADED_SERVER_ASSIGNER_DEFINES_SVH
`define LEAST_LOADED_SERVER_ASSIGNER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define LLSA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("llsa assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define LLSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("llsa assertion failed: next-cycle implication");

`else

`define LLSA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define LLSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/llsa_pkg.sv]
// Shared types and constants for the least-loaded server assigner.
package llsa_pkg;

   localparam int DUR_W   = 16;  // job duration field
   localparam int SIDX_W  = 4;   // server index field
   localparam int SPAN_W  = 32;  // makespan field
   localparam int NS_W    = 5;   // num_servers register
   localparam int CLAMP_W = 9;   // holds any server count up to 256

   // Load store control from the sequencer.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } mem_ctl_type;

   // One finished result.
   typedef struct packed {
      logic [SIDX_W-1:0] server_index;
      logic              makespan_valid;
      logic [SPAN_W-1:0] makespan;
   } res_type;

endpackage

[rtl/llsa_if.sv]
// Handshake channel interfaces: job request, assignment response, config write.
interface llsa_req_if import llsa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DUR_W-1:0] job_duration;
   logic             last_job;

   modport source (output valid, output job_duration, output last_job, input ready);
   modport sink   (input valid, input job_duration, input last_job, output ready);
endinterface

interface llsa_rsp_if import llsa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIDX_W-1:0] server_index;
   logic              makespan_valid;
   logic [SPAN_W-1:0] makespan;

   modport source (output valid, output server_index, output makespan_valid,
                   output makespan, input ready);
   modport sink   (input valid, input server_index, input makespan_valid,
                   input makespan, output ready);
endinterface

interface llsa_csr_if import llsa_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [NS_W-1:0] num_servers;

   modport source (output valid, output num_servers, input ready);
   modport sink   (input valid, input num_servers, output ready);
endinterface

[rtl/least_loaded_server_assigner.sv]
// Top level of the least-loaded server assigner (greedy list scheduling).
//
//   channel   role   carries                                         accepted when
//   req_ch    sink   job_duration, last_job                          valid && ready
//   rsp_ch    source server_index, makespan_valid, makespan          valid && ready
//   csr_ch    sink   num_servers                                     valid (ready tied high)
//
// For each job the sequencer first scans the loads of the n active servers, reading
// one load per cycle through the single memory port, then updates the chosen server,
// forms the result and returns to idle.
// Reset clears valid bits of the load store at once; no clearing pass is needed.
// A stalled response sits in the output register while the next job is scanned;
// the sequencer holds in its result state only if that register is still full.
module least_loaded_server_assigner import llsa_pkg::*; #(
   parameter int MAX_SERVERS = 16,
   parameter int LOAD_BITS   = 32
) (
   input  logic       clock,
   input  logic       reset,
   llsa_req_if.sink   req_ch,
   llsa_rsp_if.source rsp_ch,
   llsa_csr_if.sink   csr_ch
);

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

   logic [NS_W-1:0]      num_servers_ff, num_servers_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   res_type              rsp_data_ff, rsp_data_in;

   logic                 idle;
   logic                 start;
   mem_ctl_type          mem_ctl;
   logic [IDX_W-1:0]     mem_addr;
   logic [LOAD_BITS-1:0] wr_data;
   logic [LOAD_BITS-1:0] rd_data;
   logic                 res_valid;
   res_type              res;
   logic                 res_take;

   // Config register: always ready; written only between jobs, which the block does not enforce.
   assign csr_ch.ready   = 1'b1;
   assign num_servers_in = csr_ch.valid ? csr_ch.num_servers : num_servers_ff;

   // Take a new job only when the sequencer is free.
   assign req_ch.ready = idle;
   assign start        = req_ch.valid && idle;

   // Load the output register when it is empty or drains this cycle.
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_servers_ff <= NS_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         num_servers_ff <= num_servers_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload holds without reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.server_index   = rsp_data_ff.server_index;
   assign rsp_ch.makespan_valid = rsp_data_ff.makespan_valid;
   assign rsp_ch.makespan       = rsp_data_ff.makespan;

   llsa_ctrl #(
      .MAX_SERVERS (MAX_SERVERS),
      .LOAD_BITS   (LOAD_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .job_duration (req_ch.job_duration),
      .last_job     (req_ch.last_job),
      .num_servers  (num_servers_ff),
      .idle         (idle),
      .mem_ctl      (mem_ctl),
      .mem_addr     (mem_addr),
      .wr_data      (wr_data),
      .rd_data      (rd_data),
      .res_valid    (res_valid),
      .res          (res),
      .res_take     (res_take)
   );

   llsa_load_store #(
      .MAX_SERVERS (MAX_SERVERS),
      .LOAD_BITS   (LOAD_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .mem_ctl  (mem_ctl),
      .mem_addr (mem_addr),
      .wr_data  (wr_data),
      .rd_data  (rd_data)
   );

endmodule

[rtl/llsa_load_store.sv]
// Server load memory: one write/read port, registered read, per-entry valid bits.
module llsa_load_store import llsa_pkg::*; #(
   parameter int MAX_SERVERS = 16,
   parameter int LOAD_BITS   = 32,
   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mem_ctl_type          mem_ctl,
   input  logic [IDX_W-1:0]     mem_addr,
   input  logic [LOAD_BITS-1:0] wr_data,
   output logic [LOAD_BITS-1:0] rd_data
);

   logic [LOAD_BITS-1:0]   load_mem [MAX_SERVERS];
   logic [MAX_SERVERS-1:0] valid_ff;
   logic [LOAD_BITS-1:0]   rd_q_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         load_mem[mem_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_q_ff   <= load_mem[mem_addr];
         rd_vld_ff <= valid_ff[mem_addr];
      end
   end

   // Clear wins over a same-cycle write: the batch is over.
   always_ff @(posedge clock) begin
      if (reset || mem_ctl.clear_all) begin
         valid_ff <= '0;
      end else if (mem_ctl.wr_en) begin
         valid_ff[mem_addr] <= 1'b1;
      end
   end

   // An entry never written since the last clear reads as zero load.
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

[rtl/llsa_ctrl.sv]
// Sequencer: scan loads for min and max, update the chosen server, form the result.
`include "least_loaded_server_assigner_defines.svh"

module llsa_ctrl import llsa_pkg::*; #(
   parameter int MAX_SERVERS = 16,
   parameter int LOAD_BITS   = 32,
   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
   localparam int CW    = $clog2(MAX_SERVERS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DUR_W-1:0]     job_duration,
   input  logic                 last_job,
   input  logic [NS_W-1:0]      num_servers,
   output logic                 idle,
   output mem_ctl_type          mem_ctl,
   output logic [IDX_W-1:0]     mem_addr,
   output logic [LOAD_BITS-1:0] wr_data,
   input  logic [LOAD_BITS-1:0] rd_data,
   output logic                 res_valid,
   output res_type              res,
   input  logic                 res_take
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic                 last_ff, last_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic [IDX_W-1:0]     best_ff, best_in;
   logic [LOAD_BITS-1:0] min_ff, min_in;
   logic [LOAD_BITS-1:0] max_ff, max_in;
   res_type              res_ff, res_in;

   logic [CLAMP_W-1:0]      ns_ext;
   logic [CLAMP_W-1:0]      n_clamp;
   logic                    issue_now;
   logic                    first_entry;
   logic [LOAD_BITS:0]      sum;
   logic [LOAD_BITS-1:0]    new_load;
   logic [LOAD_BITS-1:0]    span_full;
   logic [LOAD_BITS+31:0]   span_ext;
   logic [SPAN_W-1:0]       span_sat;
   logic [IDX_W+SIDX_W-1:0] best_ext;

   // Server count: zero acts as one, above the store depth saturates.
   always_comb begin
      ns_ext = CLAMP_W'(num_servers);
      if (ns_ext == '0) begin
         n_clamp = CLAMP_W'(1);
      end else if (ns_ext > CLAMP_W'(MAX_SERVERS)) begin
         n_clamp = CLAMP_W'(MAX_SERVERS);
      end else begin
         n_clamp = ns_ext;
      end
   end

   // Saturating add and makespan of the update step.
   always_comb begin
      sum       = {1'b0, min_ff} + (LOAD_BITS+1)'(dur_ff);
      new_load  = sum[LOAD_BITS] ? '1 : sum[LOAD_BITS-1:0];
      span_full = (max_ff > new_load) ? max_ff : new_load;
      span_ext  = (LOAD_BITS+32)'(span_full);
      span_sat  = (span_ext[LOAD_BITS+31:32] != '0) ? '1 : span_ext[31:0];
      best_ext  = (IDX_W+SIDX_W)'(best_ff);
   end

   always_comb begin
      state_in    = state_ff;
      dur_in      = dur_ff;
      last_in     = last_ff;
      n_in        = n_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      best_in     = best_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      res_in      = res_ff;
      mem_ctl     = '0;
      mem_addr    = issue_ff[IDX_W-1:0];
      wr_data     = new_load;
      issue_now   = 1'b0;
      first_entry = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dur_in   = job_duration;
               last_in  = last_job;
               n_in     = n_clamp[CW-1:0];
               issue_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle, compare the previous read's data.
            issue_now     = issue_ff < n_ff;
            mem_ctl.rd_en = issue_now;
            pend_in       = issue_now;
            pidx_in       = issue_ff[IDX_W-1:0];
            if (issue_now) begin
               issue_in = issue_ff + CW'(1);
            end
            if (pend_ff) begin
               first_entry = (pidx_ff == '0);
               if (first_entry || (rd_data < min_ff)) begin
                  min_in  = rd_data;
                  best_in = pidx_ff;
               end
               if (first_entry || (rd_data > max_ff)) begin
                  max_in = rd_data;
               end
               if (CW'(pidx_ff) == (n_ff - CW'(1))) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            mem_ctl.wr_en          = 1'b1;
            mem_ctl.clear_all      = last_ff;
            mem_addr               = best_ff;
            res_in.server_index    = best_ext[SIDX_W-1:0];
            res_in.makespan_valid  = last_ff;
            res_in.makespan        = last_ff ? span_sat : '0;
            state_in               = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff   <= dur_in;
      last_ff  <= last_in;
      n_ff     <= n_in;
      issue_ff <= issue_in;
      pidx_ff  <= pidx_in;
      best_ff  <= best_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
      res_ff   <= res_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESULT);
   assign res       = res_ff;

   `LLSA_ASSERT_IMPL(a_write_only_in_update, clock, reset, mem_ctl.wr_en, state_ff == ST_UPDATE)
   `LLSA_ASSERT_IMPL(a_scan_index_in_range, clock, reset, (state_ff == ST_SCAN) && pend_ff, CW'(pidx_ff) < n_ff)
   `LLSA_ASSERT_NEXT(a_update_then_result, clock, reset, state_ff == ST_UPDATE, res_valid && (state_ff == ST_RESULT))

endmodule

[dv/least_loaded_server_assigner_tb.sv]
// Self-checking testbench for the least-loaded server assigner.
module least_loaded_server_assigner_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import llsa_pkg::*;

   localparam int MAX_SRV      = 16;
   localparam int LOAD_W       = 32;
   // Settle time after the drain, with slack beyond the worst job at sixteen servers.
   localparam int DRAIN_CYCLES = 24;
   // Set well above what a full run with the heaviest stalls needs.
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int RAND_PHASES  = 16;
   localparam int PHASE_ITEMS  = 34;

   // Tracks server loads and the server count, and holds the expected assignments.
   class assignment_scoreboard;
      logic [NS_W-1:0]   count_reg;
      logic [LOAD_W-1:0] load [MAX_SRV];
      res_type           expected_q[$];
      int                errors;

      function new();
         count_reg = 1;
         errors    = 0;
         foreach (load[i]) load[i] = '0;
      endfunction

      function int active_servers();
         if (count_reg == 0) return 1;
         if (count_reg > MAX_SRV) return MAX_SRV;
         return count_reg;
      endfunction

      function void set_server_count(logic [NS_W-1:0] value);
         count_reg = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Assign one accepted job and queue the result it must produce.
      function void note_job(logic [DUR_W-1:0] dur, logic is_last);
         int                n;
         int                best;
         logic [LOAD_W:0]   sum;
         logic [LOAD_W-1:0] span;
         res_type           r;
         n    = active_servers();
         best = 0;
         for (int i = 1; i < n; i++) begin
            if (load[i] < load[best]) best = i;
         end
         sum        = {1'b0, load[best]} + dur;
         load[best] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
         r.server_index   = best[SIDX_W-1:0];
         r.makespan_valid = 1'b0;
         r.makespan       = '0;
         if (is_last) begin
            span = '0;
            for (int i = 0; i < n; i++) begin
               if (load[i] > span) span = load[i];
            end
            r.makespan_valid = 1'b1;
            r.makespan       = span;
            foreach (load[i]) load[i] = '0;
         end
         expected_q.push_back(r);
      endfunction

      task flag_mismatch(string what, longint unsigned got, longint unsigned want);
         errors++;
         // Cap the log; the count keeps going.
         if (errors <= 50) $display("mismatch: %s got %0h expected %0h", what, got, want);
      endtask

      task check_result(logic [SIDX_W-1:0] idx, logic mk_valid, logic [SPAN_W-1:0] mk);
         res_type want;
         if (expected_q.size() == 0) begin
            flag_mismatch("result with nothing expected, server_index", idx, 0);
            return;
         end
         want = expected_q.pop_front();
         if (idx !== want.server_index)
            flag_mismatch("server_index", idx, want.server_index);
         if (mk_valid !== want.makespan_valid)
            flag_mismatch("makespan_valid", mk_valid, want.makespan_valid);
         if (mk !== want.makespan)
            flag_mismatch("makespan", mk, want.makespan);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int          cycle_count = 0;

   assignment_scoreboard sb;

   llsa_req_if req_ch ();
   llsa_rsp_if rsp_ch ();
   llsa_csr_if csr_ch ();

   least_loaded_server_assigner #(
      .MAX_SERVERS (MAX_SRV),
      .LOAD_BITS   (LOAD_W)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: a hung handshake ends up here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Drop the response ready at random per cycle, as the current phase asks.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Sample results at the rising edge, before the block updates its outputs.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.server_index, rsp_ch.makespan_valid, rsp_ch.makespan);
   end

   // Present one job, holding it until accepted. Enter and leave at a falling edge;
   // valid stays high when the next job follows with no gap.
   task automatic send_job(input logic [DUR_W-1:0] dur, input logic is_last);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.job_duration <= dur;
      req_ch.last_job     <= is_last;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_job(dur, is_last);
      @(negedge clock);
   endtask

   // Write the server count; only called while the block is idle.
   task automatic write_server_count(input logic [NS_W-1:0] value);
      csr_ch.valid       <= 1'b1;
      csr_ch.num_servers <= value;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_server_count(value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Stop sending, wait for every expected result, then let the block settle.
   task automatic finish_phase();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Batches of random length and content; a phase may stop in the middle of a batch,
   // so the next count write lands mid-batch. A few end markers are flipped as noise.
   task automatic run_random_phase(input int items);
      int               sent;
      int               batch_len;
      logic [DUR_W-1:0] dur;
      logic             is_last;
      sent = 0;
      while (sent < items) begin
         batch_len = $urandom_range(3 * sb.active_servers() + 2, 1);
         for (int k = 0; k < batch_len && sent < items; k++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: dur = DUR_W'($urandom_range(15));
               4:          dur = '0;
               5:          dur = '1;
               6:          dur = 16'h8000 | DUR_W'($urandom_range(16'h7FFF));
               default:    dur = DUR_W'($urandom_range(16'hFFFF));
            endcase
            is_last = (k == batch_len - 1);
            if ($urandom_range(19) == 0) is_last = ~is_last;
            send_job(dur, is_last);
            sent++;
         end
      end
   endtask

   initial begin
      logic [NS_W-1:0] count_val;
      req_ch.valid        = 1'b0;
      req_ch.job_duration = '0;
      req_ch.last_job     = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.num_servers  = '0;
      rsp_ch.ready        = 1'b0;
      idle_pct            = 0;
      stall_pct           = 0;
      reset               = 1'b1;
      sb                  = new();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Four servers: ties go to the lowest index, zero-length jobs still count,
      // and the batch with the duration extremes ends with a makespan.
      write_server_count(4);
      send_job(16'h0000, 1'b0);
      send_job(16'hFFFF, 1'b0);
      send_job(16'h0001, 1'b0);
      send_job(16'h8000, 1'b0);
      send_job(16'h7FFF, 1'b0);
      send_job(16'h0000, 1'b0);
      send_job(16'h0005, 1'b1);
      finish_phase();

      // A count of zero behaves as a single server.
      write_server_count(0);
      send_job(16'h0003, 1'b0);
      send_job(16'h0000, 1'b1);
      finish_phase();

      // Oversized count saturates to sixteen; leave the batch open.
      write_server_count(31);
      send_job(16'd10, 1'b0);
      send_job(16'd20, 1'b0);
      send_job(16'd30, 1'b0);
      finish_phase();

      // Shrink the count mid-batch: server 2 keeps its load but is left out of
      // the search and the makespan, then everything clears.
      write_server_count(2);
      send_job(16'd2, 1'b0);
      send_job(16'd1, 1'b1);
      finish_phase();

      write_server_count(16);
      send_job(16'd7, 1'b0);
      send_job(16'd7, 1'b0);
      send_job(16'd7, 1'b1);
      finish_phase();

      // Random phases, rotating through the idling modes.
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         case ($urandom_range(9))
            0:       count_val = 0;
            1:       count_val = 31;
            2:       count_val = 16;
            3:       count_val = 1;
            4:       count_val = NS_W'($urandom_range(31, 17));
            default: count_val = NS_W'($urandom_range(15, 2));
         endcase
         write_server_count(count_val);
         run_random_phase(PHASE_ITEMS);
         finish_phase();
      end

      if (sb.pending() != 0) sb.flag_mismatch("results never arrived", sb.pending(), 0);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
